// ===== rtl/nfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcd_pkg: NOR flash command decoder package
// Widths, command codes, mode and event encodings and the shared structs
// used by the decoder, its datapath and its channel interfaces.
// ----------------------------------------------------------------------------
package nfcd_pkg;

  // Bus and field widths.
  localparam int ADDR_BITS     = 22;
  localparam int SECTOR_SHIFT  = 12;
  localparam int DATA_BITS     = 16;
  localparam int CODE_BITS     = 16;
  localparam int NUM_SECTORS   = 35;
  localparam int SECTOR_BITS   = 6;
  localparam int PROT_IDX_BITS = $clog2(NUM_SECTORS);
  localparam int PTICK_BITS    = 16;
  localparam int CNT_BITS      = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 35;
  localparam int STEP_BITS     = 2;
  localparam int TOGGLE_POS    = 6;

  // Clears the in-sector offset of an address.
  localparam logic [ADDR_BITS-1:0] SECTOR_BASE_MASK =
    ~ADDR_BITS'((64'd1 << SECTOR_SHIFT) - 64'd1);

  // Command addresses (low 11 address bits) and command data (low byte).
  localparam logic [10:0] ADDR_UNLOCK1      = 11'h555;
  localparam logic [10:0] ADDR_UNLOCK2      = 11'h2AA;
  localparam logic [7:0]  DATA_UNLOCK1      = 8'hAA;
  localparam logic [7:0]  DATA_UNLOCK2      = 8'h55;
  localparam logic [7:0]  DATA_AUTOSELECT   = 8'h90;
  localparam logic [7:0]  DATA_PROGRAM      = 8'hA0;
  localparam logic [7:0]  DATA_BYPASS       = 8'h20;
  localparam logic [7:0]  DATA_ERASE_SETUP  = 8'h80;
  localparam logic [7:0]  DATA_CHIP_ERASE   = 8'h10;
  localparam logic [7:0]  DATA_SECTOR_ERASE = 8'h30;
  localparam logic [7:0]  DATA_RESET        = 8'hF0;

  // Autoselect offsets.
  localparam logic [7:0] AS_OFF_MANUF   = 8'd0;
  localparam logic [7:0] AS_OFF_DEVICE  = 8'd1;
  localparam logic [7:0] AS_OFF_PROTECT = 8'd2;

  // Unlock sequence steps.
  localparam logic [STEP_BITS-1:0] STEP_IDLE   = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_FIRST  = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_SECOND = 2'd2;
  localparam logic [STEP_BITS-1:0] STEP_BAD    = 2'd3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_READ     = 3'd0,
    MODE_AUTO     = 3'd1,
    MODE_PROG     = 3'd2,
    MODE_ERASE    = 3'd3,
    MODE_BYP      = 3'd4,
    MODE_BYP_PROG = 3'd5,
    MODE_BYP_EXIT = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    SRC_ARRAY      = 2'd0,
    SRC_AUTOSELECT = 2'd1,
    SRC_STATUS     = 2'd2
  } src_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PROGRAM      = 3'd1,
    EV_CHIP_ERASE   = 3'd2,
    EV_SECTOR_ERASE = 3'd3,
    EV_BAD_SECTOR   = 3'd4
  } event_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MANUF_CODE   = 3'd0,
    CFG_DEVICE_CODE  = 3'd1,
    CFG_PROTECT_MASK = 3'd2,
    CFG_LAST_SECTOR  = 3'd3,
    CFG_PROG_TICKS   = 3'd4,
    CFG_ERASE_TICKS  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_BITS-1:0] unlock_step;
    mode_e                mode;
    logic [CNT_BITS-1:0]  countdown;
    logic                 toggle;
  } nfcd_state_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_BITS-1:0] address;
    logic [DATA_BITS-1:0] write_data;
  } nfcd_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    src_e                 read_source;
    event_e               op_event;
    logic [ADDR_BITS-1:0] op_address;
    logic [DATA_BITS-1:0] op_data;
    logic                 busy_res;
  } nfcd_result_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]   manufacturer_code;
    logic [CODE_BITS-1:0]   device_code;
    logic [NUM_SECTORS-1:0] protect_mask;
    logic [SECTOR_BITS-1:0] last_sector;
    logic [PTICK_BITS-1:0]  program_ticks;
    logic [CNT_BITS-1:0]    erase_ticks;
  } nfcd_cfg_t;

endpackage

// ===== rtl/nfcd_if.sv =====
// ----------------------------------------------------------------------------
// nfcd_if: channel interfaces of the NOR flash command decoder
// Bus access channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface nfcd_item_if
  import nfcd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_BITS-1:0] write_data;

  modport source (output valid, command, address, write_data, input ready);
  modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface nfcd_result_if
  import nfcd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] read_data;
  logic [1:0]           read_source;
  logic [2:0]           op_event;
  logic [ADDR_BITS-1:0] op_address;
  logic [DATA_BITS-1:0] op_data;
  logic                 busy_res;

  modport source (output valid, read_data, read_source, op_event, op_address,
                  op_data, busy_res, input ready);
  modport sink   (input valid, read_data, read_source, op_event, op_address,
                  op_data, busy_res, output ready);
endinterface

interface nfcd_cfg_if
  import nfcd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nfcd_decode.sv =====
// ----------------------------------------------------------------------------
// nfcd_decode: command sequence decoder
// Takes the current state and one bus beat and produces the next state and
// the result word. Purely combinational; the caller holds all registers.
// ----------------------------------------------------------------------------
module nfcd_decode
  import nfcd_pkg::*;
(
  input  nfcd_state_t  state_i,
  input  nfcd_item_t   item_i,
  input  nfcd_cfg_t    cfg_i,
  output nfcd_state_t  state_o,
  output nfcd_result_t result_o
);

  logic [10:0]            cmd_addr;
  logic [7:0]             cmd_data;
  logic [ADDR_BITS-1:0]   sector;
  logic                   sector_bad;
  logic                   busy;
  logic                   write_ok;
  cmd_e                   cmd;
  logic [CNT_BITS-1:0]    prog_load;
  logic [CNT_BITS-1:0]    erase_load;
  mode_e                  wr_mode;
  logic [STEP_BITS-1:0]   wr_step;
  event_e                 wr_event;
  logic                   prot_bit;

  // Fields of the beat that the decode looks at.
  assign cmd        = cmd_e'(item_i.command);
  assign cmd_addr   = item_i.address[10:0];
  assign cmd_data   = item_i.write_data[7:0];
  assign sector     = item_i.address >> SECTOR_SHIFT;
  assign sector_bad = sector > ADDR_BITS'(cfg_i.last_sector);
  assign busy       = state_i.countdown != '0;
  assign write_ok   = (cmd == CMD_WRITE) && !busy;

  // A tick count of zero behaves as one.
  assign prog_load  = (cfg_i.program_ticks == '0) ? CNT_BITS'(1)
                                                  : CNT_BITS'(cfg_i.program_ticks);
  assign erase_load = (cfg_i.erase_ticks == '0) ? CNT_BITS'(1) : cfg_i.erase_ticks;

  // Protect bit of the addressed sector; sectors past the mask read zero.
  assign prot_bit = (sector < ADDR_BITS'(NUM_SECTORS)) ?
                    cfg_i.protect_mask[sector[PROT_IDX_BITS-1:0]] : 1'b0;

  // Write decode: where a bus write moves the command sequence.
  always_comb begin
    wr_mode  = state_i.mode;
    wr_step  = state_i.unlock_step;
    wr_event = EV_NONE;
    unique case (state_i.mode)
      MODE_PROG: begin
        wr_event = EV_PROGRAM;
        wr_mode  = MODE_READ;
        wr_step  = STEP_IDLE;
      end
      MODE_BYP_PROG: begin
        wr_event = EV_PROGRAM;
        wr_mode  = MODE_BYP;
        wr_step  = STEP_IDLE;
      end
      MODE_BYP: begin
        priority if (cmd_data == DATA_PROGRAM) begin
          wr_mode = MODE_BYP_PROG;
        end else if (cmd_data == DATA_AUTOSELECT) begin
          wr_mode = MODE_BYP_EXIT;
        end else begin
          wr_mode = MODE_READ;
          wr_step = STEP_IDLE;
        end
      end
      MODE_BYP_EXIT: begin
        wr_mode = MODE_READ;
        wr_step = STEP_IDLE;
      end
      MODE_ERASE: begin
        priority if (state_i.unlock_step == STEP_IDLE && cmd_addr == ADDR_UNLOCK1 &&
                     cmd_data == DATA_UNLOCK1) begin
          wr_step = STEP_FIRST;
        end else if (state_i.unlock_step == STEP_FIRST && cmd_addr == ADDR_UNLOCK2 &&
                     cmd_data == DATA_UNLOCK2) begin
          wr_step = STEP_SECOND;
        end else if (state_i.unlock_step == STEP_SECOND && cmd_addr == ADDR_UNLOCK1 &&
                     cmd_data == DATA_CHIP_ERASE) begin
          wr_event = EV_CHIP_ERASE;
          wr_mode  = MODE_READ;
          wr_step  = STEP_IDLE;
        end else if (state_i.unlock_step == STEP_SECOND &&
                     cmd_data == DATA_SECTOR_ERASE) begin
          wr_event = sector_bad ? EV_BAD_SECTOR : EV_SECTOR_ERASE;
          wr_mode  = MODE_READ;
          wr_step  = STEP_IDLE;
        end else begin
          wr_mode = MODE_READ;
          wr_step = STEP_IDLE;
        end
      end
      default: begin
        // Read array, autoselect and any unused code.
        priority if (cmd_data == DATA_RESET) begin
          wr_mode = MODE_READ;
          wr_step = STEP_IDLE;
        end else if (state_i.unlock_step == STEP_IDLE && cmd_addr == ADDR_UNLOCK1 &&
                     cmd_data == DATA_UNLOCK1) begin
          wr_step = STEP_FIRST;
        end else if (state_i.unlock_step == STEP_FIRST && cmd_addr == ADDR_UNLOCK2 &&
                     cmd_data == DATA_UNLOCK2) begin
          wr_step = STEP_SECOND;
        end else if (state_i.unlock_step == STEP_SECOND &&
                     cmd_addr == ADDR_UNLOCK1) begin
          wr_step = STEP_IDLE;
          priority if (cmd_data == DATA_AUTOSELECT) begin
            wr_mode = MODE_AUTO;
          end else if (cmd_data == DATA_PROGRAM) begin
            wr_mode = MODE_PROG;
          end else if (cmd_data == DATA_BYPASS) begin
            wr_mode = MODE_BYP;
          end else if (cmd_data == DATA_ERASE_SETUP) begin
            wr_mode = MODE_ERASE;
          end else begin
            wr_mode = MODE_READ;
          end
        end else begin
          wr_mode = MODE_READ;
          wr_step = STEP_IDLE;
        end
      end
    endcase
  end

  // Next state: reads flip the toggle bit while busy, writes move the
  // sequence when idle, ticks count the busy time down.
  always_comb begin
    state_o = state_i;
    unique case (cmd)
      CMD_READ: begin
        if (busy) begin
          state_o.toggle = ~state_i.toggle;
        end
      end
      CMD_WRITE: begin
        if (!busy) begin
          state_o.mode        = wr_mode;
          state_o.unlock_step = wr_step;
          if (wr_event == EV_PROGRAM) begin
            state_o.countdown = prog_load;
          end else if (wr_event == EV_CHIP_ERASE || wr_event == EV_SECTOR_ERASE) begin
            state_o.countdown = erase_load;
          end
        end
      end
      CMD_TICK: begin
        if (busy) begin
          state_o.countdown = state_i.countdown - CNT_BITS'(1);
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  // Outputs: read answer, operation event and busy flag.
  always_comb begin
    result_o             = '0;
    result_o.read_source = SRC_ARRAY;
    result_o.op_event    = EV_NONE;
    if (cmd == CMD_READ) begin
      if (busy) begin
        result_o.read_source = SRC_STATUS;
        result_o.read_data   = DATA_BITS'({state_i.toggle, TOGGLE_POS'(0)});
      end else if (state_i.mode == MODE_AUTO) begin
        result_o.read_source = SRC_AUTOSELECT;
        priority if (item_i.address[7:0] == AS_OFF_MANUF) begin
          result_o.read_data = DATA_BITS'(cfg_i.manufacturer_code);
        end else if (item_i.address[7:0] == AS_OFF_DEVICE) begin
          result_o.read_data = DATA_BITS'(cfg_i.device_code);
        end else if (item_i.address[7:0] == AS_OFF_PROTECT) begin
          result_o.read_data = DATA_BITS'(prot_bit);
        end else begin
          result_o.read_data = '0;
        end
      end
    end
    if (write_ok) begin
      result_o.op_event = wr_event;
      unique case (wr_event)
        EV_PROGRAM: begin
          result_o.op_address = item_i.address;
          result_o.op_data    = item_i.write_data;
        end
        EV_SECTOR_ERASE, EV_BAD_SECTOR: begin
          result_o.op_address = item_i.address & SECTOR_BASE_MASK;
        end
        default: begin
          result_o.op_address = '0;
        end
      endcase
    end
    result_o.busy_res = state_o.countdown != '0;
  end

endmodule

// ===== rtl/nor_flash_command_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// nor_flash_command_decoder_unit: NOR flash command decoder, device side
// Follows the unlock sequence and decodes autoselect, program, unlock
// bypass, chip and sector erase and reset, and answers status reads while
// an embedded operation counts down.
//
//   Channel  Dir  Handshake      Beat contents
//   cmd_i    in   valid/ready    command, address, write_data
//   res_o    out  valid/ready    read_data, read_source, op_event,
//                                op_address, op_data, busy_res
//   cfg_i    in   valid/ready    index, data (register write)
//
// One beat per cycle is sustained on cmd_i while res_o is not stalled; each
// accepted beat gives one result beat, through the input register and then
// the result register. Reset puts the control registers at their defaults
// and the decoder in read array mode; no clearing pass is needed. A stalled
// result holds in the result register while the input register still
// takes the next beat; cmd_i.ready drops only when both are full and res_o
// is stalled. cfg_i is always ready.
// ----------------------------------------------------------------------------
module nor_flash_command_decoder_unit
  import nfcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  nfcd_item_if.sink    cmd_i,
  nfcd_result_if.source res_o,
  nfcd_cfg_if.sink     cfg_i
);

  nfcd_cfg_t    cfg_q, cfg_d;
  nfcd_state_t  state_q, state_d;
  nfcd_item_t   item_q;
  logic         item_valid_q, item_valid_d;
  nfcd_result_t res_q, res_d;
  logic         res_valid_q, res_valid_d;
  logic         advance;
  logic         cmd_accept;

  // Pipeline control.
  assign advance      = item_valid_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready  = !item_valid_q || advance;
  assign cmd_accept   = cmd_i.valid && cmd_i.ready;
  assign item_valid_d = cmd_accept ? 1'b1 : (advance ? 1'b0 : item_valid_q);
  assign res_valid_d  = advance ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);
  assign cfg_i.ready  = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_MANUF_CODE:   cfg_d.manufacturer_code = cfg_i.data[CODE_BITS-1:0];
        CFG_DEVICE_CODE:  cfg_d.device_code       = cfg_i.data[CODE_BITS-1:0];
        CFG_PROTECT_MASK: cfg_d.protect_mask      = cfg_i.data[NUM_SECTORS-1:0];
        CFG_LAST_SECTOR:  cfg_d.last_sector       = cfg_i.data[SECTOR_BITS-1:0];
        CFG_PROG_TICKS:   cfg_d.program_ticks     = cfg_i.data[PTICK_BITS-1:0];
        CFG_ERASE_TICKS:  cfg_d.erase_ticks       = cfg_i.data[CNT_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Decode of the registered beat.
  nfcd_decode u_decode (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.manufacturer_code <= CODE_BITS'(1);
      cfg_q.device_code       <= CODE_BITS'(8919);
      cfg_q.protect_mask      <= '0;
      cfg_q.last_sector       <= SECTOR_BITS'(34);
      cfg_q.program_ticks     <= PTICK_BITS'(16);
      cfg_q.erase_ticks       <= CNT_BITS'(100000);
      state_q.unlock_step     <= STEP_IDLE;
      state_q.mode            <= MODE_READ;
      state_q.countdown       <= '0;
      state_q.toggle          <= 1'b0;
      item_valid_q            <= 1'b0;
      res_valid_q             <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      item_q.command    <= cmd_i.command;
      item_q.address    <= cmd_i.address;
      item_q.write_data <= cmd_i.write_data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Result channel.
  assign res_o.valid       = res_valid_q;
  assign res_o.read_data   = res_q.read_data;
  assign res_o.read_source = res_q.read_source;
  assign res_o.op_event    = res_q.op_event;
  assign res_o.op_address  = res_q.op_address;
  assign res_o.op_data     = res_q.op_data;
  assign res_o.busy_res    = res_q.busy_res;

`ifndef NO_ASSERTIONS
  // The busy flag of a new result matches the countdown it leaves behind.
  a_busy_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.busy_res == (state_q.countdown != '0)))
    else $error("busy_res does not match the busy countdown");

  // A started program or erase always makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.op_event == EV_PROGRAM || res_d.op_event == EV_CHIP_ERASE ||
                res_d.op_event == EV_SECTOR_ERASE) |=> res_q.busy_res)
    else $error("operation started without going busy");

  // Status words are only given while an operation runs.
  a_status_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.read_source == SRC_STATUS) |-> res_q.busy_res)
    else $error("status read returned while idle");

  // The unlock sequence has three steps only.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.unlock_step != STEP_BAD)
    else $error("unlock step out of range");
`endif

endmodule

// ===== sim/nfcd_decode_checker.sv =====
// ----------------------------------------------------------------------------
// nfcd_decode_checker: result checker for the NOR flash command decoder
// Watches the bus access, result and register channels, keeps its own copy
// of the decoder state and settings, works out the result of every accepted
// bus beat and compares each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module nfcd_decode_checker
  import nfcd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  nfcd_item_if   cmd_i,
  nfcd_result_if res_i,
  nfcd_cfg_if    cfg_i,
  output int     awaited_o,
  output int     mismatch_count_o
);

  // Shadow copy of the decoder state and its register settings.
  logic [STEP_BITS-1:0] unlock_step;
  mode_e                op_mode;
  logic [CNT_BITS-1:0]  countdown;
  logic                 toggle;
  nfcd_cfg_t            settings;

  nfcd_result_t         awaited_results[$];
  nfcd_result_t         oldest;
  int                   mismatch_count;

  assign mismatch_count_o = mismatch_count;

  // A tick count of zero behaves as a count of one.
  function automatic logic [CNT_BITS-1:0] at_least_one(input logic [CNT_BITS-1:0] t);
    return (t == '0) ? CNT_BITS'(1) : t;
  endfunction

  function automatic void return_to_read();
    op_mode     = MODE_READ;
    unlock_step = STEP_IDLE;
  endfunction

  // Works out the result of one bus beat and advances the shadow state.
  function automatic nfcd_result_t decode_access(input logic [1:0]           command,
                                                 input logic [ADDR_BITS-1:0] address,
                                                 input logic [DATA_BITS-1:0] data);
    nfcd_result_t                      r;
    logic [ADDR_BITS-SECTOR_SHIFT-1:0] sector;
    logic [10:0]                       cmd_addr;
    logic [7:0]                        cmd_data;
    r        = '0;
    sector   = address[ADDR_BITS-1:SECTOR_SHIFT];
    cmd_addr = address[10:0];
    cmd_data = data[7:0];
    case (command)
      CMD_READ: begin
        if (countdown != '0) begin
          // Status read while an embedded operation runs.
          r.read_data[TOGGLE_POS] = toggle;
          r.read_source           = SRC_STATUS;
          toggle                  = ~toggle;
        end else if (op_mode == MODE_AUTO) begin
          r.read_source = SRC_AUTOSELECT;
          case (address[7:0])
            AS_OFF_MANUF:   r.read_data = settings.manufacturer_code;
            AS_OFF_DEVICE:  r.read_data = settings.device_code;
            AS_OFF_PROTECT: begin
              if (sector < NUM_SECTORS) begin
                r.read_data =
                  DATA_BITS'(settings.protect_mask[sector[PROT_IDX_BITS-1:0]]);
              end
            end
            default: ;
          endcase
        end
      end
      CMD_WRITE: begin
        // Writes are dropped while busy.
        if (countdown == '0) begin
          case (op_mode)
            MODE_PROG, MODE_BYP_PROG: begin
              r.op_event   = EV_PROGRAM;
              r.op_address = address;
              r.op_data    = data;
              countdown    = at_least_one(CNT_BITS'(settings.program_ticks));
              op_mode      = (op_mode == MODE_BYP_PROG) ? MODE_BYP : MODE_READ;
              unlock_step  = STEP_IDLE;
            end
            MODE_BYP: begin
              if (cmd_data == DATA_PROGRAM) begin
                op_mode = MODE_BYP_PROG;
              end else if (cmd_data == DATA_AUTOSELECT) begin
                op_mode = MODE_BYP_EXIT;
              end else begin
                return_to_read();
              end
            end
            MODE_BYP_EXIT: return_to_read();
            MODE_ERASE: begin
              if (unlock_step == STEP_IDLE && cmd_addr == ADDR_UNLOCK1 &&
                  cmd_data == DATA_UNLOCK1) begin
                unlock_step = STEP_FIRST;
              end else if (unlock_step == STEP_FIRST && cmd_addr == ADDR_UNLOCK2 &&
                           cmd_data == DATA_UNLOCK2) begin
                unlock_step = STEP_SECOND;
              end else if (unlock_step == STEP_SECOND && cmd_addr == ADDR_UNLOCK1 &&
                           cmd_data == DATA_CHIP_ERASE) begin
                r.op_event = EV_CHIP_ERASE;
                countdown  = at_least_one(settings.erase_ticks);
                return_to_read();
              end else if (unlock_step == STEP_SECOND && cmd_data == DATA_SECTOR_ERASE) begin
                r.op_address = {sector, SECTOR_SHIFT'(0)};
                if (sector > settings.last_sector) begin
                  r.op_event = EV_BAD_SECTOR;
                end else begin
                  r.op_event = EV_SECTOR_ERASE;
                  countdown  = at_least_one(settings.erase_ticks);
                end
                return_to_read();
              end else begin
                return_to_read();
              end
            end
            default: begin
              // Read array and autoselect modes share the unlock decode.
              if (cmd_data == DATA_RESET) begin
                return_to_read();
              end else if (unlock_step == STEP_IDLE && cmd_addr == ADDR_UNLOCK1 &&
                           cmd_data == DATA_UNLOCK1) begin
                unlock_step = STEP_FIRST;
              end else if (unlock_step == STEP_FIRST && cmd_addr == ADDR_UNLOCK2 &&
                           cmd_data == DATA_UNLOCK2) begin
                unlock_step = STEP_SECOND;
              end else if (unlock_step == STEP_SECOND && cmd_addr == ADDR_UNLOCK1) begin
                unlock_step = STEP_IDLE;
                case (cmd_data)
                  DATA_AUTOSELECT:  op_mode = MODE_AUTO;
                  DATA_PROGRAM:     op_mode = MODE_PROG;
                  DATA_BYPASS:      op_mode = MODE_BYP;
                  DATA_ERASE_SETUP: op_mode = MODE_ERASE;
                  default:          return_to_read();
                endcase
              end else begin
                return_to_read();
              end
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (countdown != '0) begin
          countdown = countdown - CNT_BITS'(1);
        end
      end
      default: ;
    endcase
    r.busy_res = (countdown != '0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track register writes and bus beats, and check every result beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_step                = STEP_IDLE;
      op_mode                    = MODE_READ;
      countdown                  = '0;
      toggle                     = 1'b0;
      settings.manufacturer_code = 16'd1;
      settings.device_code       = 16'd8919;
      settings.protect_mask      = '0;
      settings.last_sector       = 6'd34;
      settings.program_ticks     = 16'd16;
      settings.erase_ticks       = 24'd100000;
      awaited_results.delete();
      mismatch_count             = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MANUF_CODE:   settings.manufacturer_code = cfg_i.data[CODE_BITS-1:0];
          CFG_DEVICE_CODE:  settings.device_code       = cfg_i.data[CODE_BITS-1:0];
          CFG_PROTECT_MASK: settings.protect_mask      = cfg_i.data[NUM_SECTORS-1:0];
          CFG_LAST_SECTOR:  settings.last_sector       = cfg_i.data[SECTOR_BITS-1:0];
          CFG_PROG_TICKS:   settings.program_ticks     = cfg_i.data[PTICK_BITS-1:0];
          CFG_ERASE_TICKS:  settings.erase_ticks       = cfg_i.data[CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        awaited_results.push_back(decode_access(cmd_i.command, cmd_i.address,
                                                cmd_i.write_data));
      end
      if (res_i.valid && res_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat expected none, actual read_data 0x%0h event %0d",
                   $time, res_i.read_data, res_i.op_event);
          mismatch_count++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("read_data", 32'(oldest.read_data), 32'(res_i.read_data));
          check_field("read_source", 32'(oldest.read_source), 32'(res_i.read_source));
          check_field("op_event", 32'(oldest.op_event), 32'(res_i.op_event));
          check_field("op_address", 32'(oldest.op_address), 32'(res_i.op_address));
          check_field("op_data", 32'(oldest.op_data), 32'(res_i.op_data));
          check_field("busy_res", 32'(oldest.busy_res), 32'(res_i.busy_res));
        end
      end
    end
    awaited_o = awaited_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level of the NOR flash command decoder simulation
// Drives bus reads, writes and ticks and register writes into the decoder,
// stalls the result side at random, and gives the verdict from the checker's
// mismatch count. Directed beats cover the special cases, then random
// command sequences run under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import nfcd_pkg::*;

  localparam int          WATCHDOG_LIMIT   = 3000;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          END_WAIT_CYCLES  = 8;
  localparam logic [1:0]  CMD_UNUSED       = 2'd3;
  localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;
  localparam logic [7:0]  DATA_BYPASS_EXIT = 8'h00;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nfcd_item_if   cmd_if ();
  nfcd_result_if res_if ();
  nfcd_cfg_if    cfg_if ();

  int   awaited;
  int   mismatches;

  // Stimulus bookkeeping.
  int   beats_sent;
  int   reg_writes;
  int   settings_count;
  int   prog_span;
  int   erase_span;
  bit   quiet_stretch;
  bit   hold_request;
  int   hold_left;
  int   stall_cycles;

  always #5 clk_i = ~clk_i;

  nor_flash_command_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  nfcd_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_if),
    .res_i            (res_if),
    .cfg_i            (cfg_if),
    .awaited_o        (awaited),
    .mismatch_count_o (mismatches)
  );

  // Offers one bus beat, sometimes after a one-cycle gap, and waits for it to go.
  task automatic send_beat(input logic [1:0] command, input logic [ADDR_BITS-1:0] address,
                           input logic [DATA_BITS-1:0] data);
    if (!quiet_stretch && $urandom_range(99) < 6) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= command;
    cmd_if.address    <= address;
    cmd_if.write_data <= data;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Command writes match on the low address bits and the low data byte only,
  // so the upper bits are random.
  task automatic command_write(input logic [10:0] low_addr, input logic [7:0] low_data);
    send_beat(CMD_WRITE, {11'($urandom), low_addr}, {8'($urandom), low_data});
  endtask

  task automatic unlock();
    command_write(ADDR_UNLOCK1, DATA_UNLOCK1);
    command_write(ADDR_UNLOCK2, DATA_UNLOCK2);
  endtask

  task automatic erase_setup();
    unlock();
    command_write(ADDR_UNLOCK1, DATA_ERASE_SETUP);
    unlock();
  endtask

  task automatic random_beat(input logic [1:0] command);
    send_beat(command, ADDR_BITS'($urandom), DATA_BITS'($urandom));
  endtask

  // Autoselect read: sector in the upper bits, offset in the low byte.
  task automatic autoselect_read(input int sector, input logic [7:0] offset);
    send_beat(CMD_READ, {10'(sector), 4'($urandom), offset}, DATA_BITS'($urandom));
  endtask

  // Ticks past a busy period, with status reads and dropped writes mixed in.
  task automatic tick_through(input int span);
    repeat (span + $urandom_range(0, 2)) begin
      if ($urandom_range(99) < 30) random_beat(CMD_READ);
      if ($urandom_range(99) < 8) random_beat(CMD_WRITE);
      random_beat(CMD_TICK);
    end
  endtask

  // Stops offering beats until every awaited result has arrived.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (END_WAIT_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Writes all six registers; unused upper data bits carry random noise.
  task automatic apply_settings(input logic [15:0] manuf, input logic [15:0] device,
                                input logic [34:0] protect, input logic [5:0] last,
                                input logic [15:0] prog_ticks, input logic [23:0] erase_ticks);
    write_reg(CFG_MANUF_CODE, {19'($urandom), manuf});
    write_reg(CFG_DEVICE_CODE, {19'($urandom), device});
    write_reg(CFG_PROTECT_MASK, protect);
    write_reg(CFG_LAST_SECTOR, {29'($urandom), last});
    write_reg(CFG_PROG_TICKS, {19'($urandom), prog_ticks});
    write_reg(CFG_ERASE_TICKS, {11'($urandom), erase_ticks});
    prog_span  = (prog_ticks == '0) ? 1 : int'(prog_ticks);
    erase_span = (erase_ticks == '0) ? 1 : int'(erase_ticks);
    settings_count++;
  endtask

  task automatic random_settings();
    apply_settings(16'($urandom), 16'($urandom), {3'($urandom), 32'($urandom)},
                   6'($urandom_range(0, 40)), 16'($urandom_range(0, 6)),
                   24'($urandom_range(0, 12)));
  endtask

  // One random command sequence: mostly well formed, the rest broken or noise.
  task automatic run_sequence();
    int pick;
    int sector;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // Autoselect entry, a few id and protect reads, then leave or not.
      unlock();
      command_write(ADDR_UNLOCK1, DATA_AUTOSELECT);
      repeat ($urandom_range(1, 5)) begin
        sector = ($urandom_range(99) < 80) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
        if ($urandom_range(99) < 75) begin
          autoselect_read(sector, 8'($urandom_range(0, 2)));
        end else begin
          autoselect_read(sector, 8'($urandom));
        end
      end
      if ($urandom_range(99) < 50) begin
        send_beat(CMD_WRITE, ADDR_BITS'($urandom), {8'($urandom), DATA_RESET});
      end else if ($urandom_range(99) < 50) begin
        random_beat(CMD_WRITE);
      end
    end else if (pick < 30) begin
      unlock();
      command_write(ADDR_UNLOCK1, DATA_PROGRAM);
      random_beat(CMD_WRITE);
      tick_through(prog_span);
    end else if (pick < 45) begin
      // Unlock bypass with a few fast programs, then exit or a stray write.
      unlock();
      command_write(ADDR_UNLOCK1, DATA_BYPASS);
      repeat ($urandom_range(1, 4)) begin
        send_beat(CMD_WRITE, ADDR_BITS'($urandom), {8'($urandom), DATA_PROGRAM});
        random_beat(CMD_WRITE);
        tick_through(prog_span);
      end
      if ($urandom_range(99) < 70) begin
        send_beat(CMD_WRITE, ADDR_BITS'($urandom), {8'($urandom), DATA_AUTOSELECT});
        if ($urandom_range(99) < 60) begin
          send_beat(CMD_WRITE, ADDR_BITS'($urandom), {8'h00, DATA_BYPASS_EXIT});
        end else begin
          random_beat(CMD_WRITE);
        end
      end else begin
        random_beat(CMD_WRITE);
      end
    end else if (pick < 55) begin
      erase_setup();
      command_write(ADDR_UNLOCK1, DATA_CHIP_ERASE);
      tick_through(erase_span);
    end else if (pick < 72) begin
      // Sector erase, both inside and past the last sector.
      erase_setup();
      sector = ($urandom_range(99) < 70) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
      send_beat(CMD_WRITE, {10'(sector), 12'($urandom)}, {8'($urandom), DATA_SECTOR_ERASE});
      tick_through(erase_span);
    end else if (pick < 78) begin
      send_beat(CMD_WRITE, ADDR_BITS'($urandom), {8'($urandom), DATA_RESET});
    end else if (pick < 90) begin
      // Broken sequences: a stray write after a partial unlock, after a full
      // unlock, or inside an erase setup.
      case ($urandom_range(2))
        0: command_write(ADDR_UNLOCK1, DATA_UNLOCK1);
        1: unlock();
        default: begin
          unlock();
          command_write(ADDR_UNLOCK1, DATA_ERASE_SETUP);
          if ($urandom_range(1) == 0) unlock();
        end
      endcase
      random_beat(CMD_WRITE);
    end else begin
      repeat ($urandom_range(1, 6)) random_beat(2'($urandom_range(0, 3)));
    end
  endtask

  task automatic random_phase(input int beats);
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) run_sequence();
  endtask

  // Result side: random stalls, plus one long hold on request.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results awaited",
               $time, stall_cycles, awaited);
      $display("nor_flash_command_decoder_unit test failed");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_READ;
    cmd_if.address    <= '0;
    cmd_if.write_data <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_MANUF_CODE;
    cfg_if.data       <= '0;
    stall_cycles      = 0;
    hold_left         = 0;
    hold_request      = 1'b0;
    quiet_stretch     = 1'b0;
    prog_span         = 16;
    erase_span        = 100000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: array read, default ids, unused command, idle tick.
    random_beat(CMD_READ);
    unlock();
    command_write(ADDR_UNLOCK1, DATA_AUTOSELECT);
    autoselect_read(0, AS_OFF_MANUF);
    autoselect_read(0, AS_OFF_DEVICE);
    send_beat(CMD_WRITE, '0, {8'h00, DATA_RESET});
    random_beat(CMD_UNUSED);
    random_beat(CMD_TICK);
    drain();

    // Extreme settings with zero tick counts, plus the unused register index.
    apply_settings(16'hFFFF, 16'h0000, {35{1'b1}}, 6'd0, 16'd0, 24'd0);
    write_reg(CFG_UNUSED_INDEX, {CFG_DATA_BITS{1'b1}});
    unlock();
    command_write(ADDR_UNLOCK1, DATA_AUTOSELECT);
    autoselect_read(34, AS_OFF_PROTECT);
    autoselect_read(35, AS_OFF_PROTECT);
    autoselect_read(1023, 8'hFF);
    unlock();
    command_write(ADDR_UNLOCK1, DATA_PROGRAM);
    send_beat(CMD_WRITE, {ADDR_BITS{1'b1}}, {DATA_BITS{1'b1}});
    random_beat(CMD_READ);
    random_beat(CMD_READ);
    send_beat(CMD_WRITE, '0, {8'h00, DATA_RESET});
    random_beat(CMD_TICK);
    erase_setup();
    send_beat(CMD_WRITE, {10'd0, 12'hFFF}, {8'hFF, DATA_SECTOR_ERASE});
    random_beat(CMD_TICK);
    erase_setup();
    send_beat(CMD_WRITE, {ADDR_BITS{1'b1}}, {8'h00, DATA_SECTOR_ERASE});
    erase_setup();
    command_write(ADDR_UNLOCK1, DATA_CHIP_ERASE);
    random_beat(CMD_TICK);
    unlock();
    command_write(ADDR_UNLOCK1, DATA_BYPASS);
    send_beat(CMD_WRITE, '0, {8'h00, DATA_PROGRAM});
    send_beat(CMD_WRITE, '0, '0);
    random_beat(CMD_TICK);
    send_beat(CMD_WRITE, '0, {8'h00, DATA_AUTOSELECT});
    send_beat(CMD_WRITE, '0, {8'h00, DATA_BYPASS_EXIT});
    drain();

    // Random sequences, first with no idling at all on either side.
    quiet_stretch = 1'b1;
    random_settings();
    random_phase(200);
    drain();
    quiet_stretch = 1'b0;

    // Long hold on the result side while beats keep coming.
    random_settings();
    hold_request = 1'b1;
    random_phase(250);
    drain();

    // Opposite extremes: highest last sector, nothing protected, one-tick busy.
    apply_settings(16'h0000, 16'hFFFF, '0, 6'd63, 16'd1, 24'd1);
    random_phase(200);
    drain();

    random_settings();
    random_phase(250);
    drain();

    // Longest tick counts: a program that stays busy to the end of the run.
    apply_settings(16'($urandom), 16'($urandom), {3'($urandom), 32'($urandom)}, 6'd63,
                   16'hFFFF, 24'hFFFFFF);
    unlock();
    command_write(ADDR_UNLOCK1, DATA_PROGRAM);
    random_beat(CMD_WRITE);
    repeat (3) random_beat(CMD_READ);
    erase_setup();
    repeat (3) random_beat(CMD_TICK);
    random_beat(CMD_READ);
    drain();

    $display("Covered %0d bus beats and %0d register writes over %0d register settings,",
             beats_sent, reg_writes, settings_count);
    $display("with unlock, autoselect, program, bypass, erase and broken sequences.");
    if (mismatches == 0) begin
      $display("nor_flash_command_decoder_unit test passed");
    end else begin
      $display("nor_flash_command_decoder_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nfcd_pkg.sv
rtl/nfcd_if.sv
rtl/nfcd_decode.sv
rtl/nor_flash_command_decoder_unit.sv
sim/nfcd_decode_checker.sv
sim/testbench.sv
